>>> rtl/tlfr_pkg.sv
// Shared types, sizes and codes for the text line framer ring.
package tlfr_pkg;

	localparam int LINE_SLOTS  = 8;
	localparam int LINE_BYTES  = 128;
	localparam int QUEUE_DEPTH = 2;

	localparam int SLOT_W   = $clog2(LINE_SLOTS);
	localparam int LEN_W    = $clog2(LINE_BYTES);
	localparam int OFS_W    = 7;
	localparam int BYTE_W   = 8;
	localparam int OUT_LEN_W = 7;
	localparam int CMP_W    = (LEN_W > OFS_W) ? LEN_W : OFS_W;
	localparam int STORE_DEPTH = LINE_SLOTS * LINE_BYTES;
	localparam int ADDR_W   = $clog2(STORE_DEPTH);

	localparam logic [BYTE_W-1:0] CHAR_PROMPT = 8'h3E;
	localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;

	typedef enum logic [1:0] {
		OP_RECV    = 2'd0,
		OP_READ    = 2'd1,
		OP_RELEASE = 2'd2,
		OP_CLEAR   = 2'd3
	} tlfr_op_t;

	typedef enum logic [2:0] {
		CMD_APPEND,
		CMD_PROMPT,
		CMD_NEWLINE,
		CMD_IGNORE,
		CMD_READ,
		CMD_RELEASE,
		CMD_CLEAR
	} tlfr_cmd_t;

	typedef struct packed {
		tlfr_cmd_t          cmd;
		logic [BYTE_W-1:0]  data;
		logic [OFS_W-1:0]   offset;
	} tlfr_item_t;

endpackage

>>> rtl/tlfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tlfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/tlfr_front.sv
// Front end: classifies an incoming transaction into a framer command.
module tlfr_front import tlfr_pkg::*; (
	input  logic [1:0]        op,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic [OFS_W-1:0]  char_offset,
	output tlfr_item_t        item
);

	always_comb begin
		item.data   = rx_byte;
		item.offset = char_offset;
		unique case (tlfr_op_t'(op))
			OP_RECV: begin
				if (rx_byte == CHAR_PROMPT) begin
					item.cmd = CMD_PROMPT;
				end else if (rx_byte == CHAR_CR) begin
					item.cmd = CMD_IGNORE;
				end else if (rx_byte == CHAR_LF) begin
					item.cmd = CMD_NEWLINE;
				end else begin
					item.cmd = CMD_APPEND;
				end
			end
			OP_READ:    item.cmd = CMD_READ;
			OP_RELEASE: item.cmd = CMD_RELEASE;
			OP_CLEAR:   item.cmd = CMD_CLEAR;
			default:    item.cmd = CMD_IGNORE;
		endcase
	end

endmodule

>>> rtl/tlfr_queue.sv
// Short command queue between the front end and the line engine.
module tlfr_queue import tlfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  tlfr_item_t push_item,
	output logic       full,
	input  logic       pop,
	output logic       head_valid,
	output tlfr_item_t head_item
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	tlfr_item_t        entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/tlfr_back.sv
// Line engine: ring pointers, line lengths, character store and result register.
module tlfr_back import tlfr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  tlfr_item_t           head_item,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 line_closed,
	output logic                 dropped_oldest,
	output logic                 oldest_ready,
	output logic [OUT_LEN_W-1:0] oldest_length,
	output logic [BYTE_W-1:0]    read_char
);

	// ring state
	logic [SLOT_W-1:0] wr_slot_q, rd_slot_q;
	logic [LEN_W-1:0]  wr_len_q;
	logic [LEN_W-1:0]  len_q [LINE_SLOTS];

	// next state
	logic [SLOT_W-1:0] wr_slot_d, rd_slot_d, wr_next, rd_next;
	logic [LEN_W-1:0]  wr_len_d, close_len, cur_rd_len, new_rd_len;
	logic [LEN_W-1:0]  len_d [LINE_SLOTS];
	logic              do_close, dropped, hit;

	// store port
	logic              st_we, st_re;
	logic [ADDR_W-1:0] st_waddr, st_raddr;
	logic [BYTE_W-1:0] st_wdata, st_rdata;

	// stage 1 and result register
	logic                 valid_s1, closed_s1, dropped_s1, ready_s1, hit_s1;
	logic [OUT_LEN_W-1:0] len_s1;
	logic                 move_s1, take;

	assign move_s1 = valid_s1 && (!out_valid || !out_stall);
	assign take    = head_valid && (!valid_s1 || move_s1);
	assign pop     = take;

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		slot_inc = (s == SLOT_W'(LINE_SLOTS - 1)) ? '0 : s + SLOT_W'(1);
	endfunction

	function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] s,
			input logic [ADDR_W-1:0] pos);
		store_addr = ADDR_W'(s) * ADDR_W'(LINE_BYTES) + pos;
	endfunction

	assign wr_next    = slot_inc(wr_slot_q);
	assign rd_next    = slot_inc(rd_slot_q);
	assign cur_rd_len = (rd_slot_q == wr_slot_q) ? wr_len_q : len_q[rd_slot_q];
	assign hit        = CMP_W'(head_item.offset) < CMP_W'(cur_rd_len);

	always_comb begin
		wr_slot_d = wr_slot_q;
		rd_slot_d = rd_slot_q;
		wr_len_d  = wr_len_q;
		do_close  = 1'b0;
		close_len = wr_len_q;
		dropped   = 1'b0;
		st_we     = 1'b0;
		st_re     = 1'b0;
		st_waddr  = store_addr(wr_slot_q, ADDR_W'(wr_len_q));
		st_wdata  = head_item.data;
		st_raddr  = store_addr(rd_slot_q, ADDR_W'(head_item.offset));
		case (head_item.cmd)
			CMD_APPEND: begin
				if (wr_len_q < LEN_W'(LINE_BYTES - 1)) begin
					st_we    = 1'b1;
					wr_len_d = wr_len_q + LEN_W'(1);
				end
			end
			CMD_PROMPT: begin
				// prompt replaces the partial line and closes at once
				st_we     = 1'b1;
				st_waddr  = store_addr(wr_slot_q, '0);
				close_len = LEN_W'(1);
				do_close  = 1'b1;
			end
			CMD_NEWLINE: begin
				do_close = (wr_len_q != '0);
			end
			CMD_READ: begin
				st_re = 1'b1;
			end
			CMD_RELEASE: begin
				// the read slot holds a finished line exactly when it trails the write slot
				if (rd_slot_q != wr_slot_q) begin
					rd_slot_d = rd_next;
				end
			end
			CMD_CLEAR: begin
				rd_slot_d = wr_slot_q;
				wr_len_d  = '0;
			end
			default: begin
			end
		endcase
		if (do_close) begin
			wr_slot_d = wr_next;
			wr_len_d  = '0;
			if (wr_next == rd_slot_q) begin
				rd_slot_d = rd_next;
				dropped   = 1'b1;
			end
		end
		for (int i = 0; i < LINE_SLOTS; i++) begin
			len_d[i] = len_q[i];
		end
		if (do_close) begin
			len_d[wr_slot_q] = close_len;
		end
		new_rd_len = (rd_slot_d == wr_slot_d) ? wr_len_d : len_d[rd_slot_d];
	end

	tlfr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (take && st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.re   (take && st_re),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	// length table: written only on close, no reset needed (never read before written)
	always_ff @(posedge clk) begin
		if (take && do_close) begin
			len_q[wr_slot_q] <= close_len;
		end
		if (take) begin
			closed_s1  <= do_close;
			dropped_s1 <= dropped;
			ready_s1   <= (rd_slot_d != wr_slot_d);
			len_s1     <= OUT_LEN_W'(new_rd_len);
			hit_s1     <= (head_item.cmd == CMD_READ) && hit;
		end
		if (move_s1) begin
			line_closed    <= closed_s1;
			dropped_oldest <= dropped_s1;
			oldest_ready   <= ready_s1;
			oldest_length  <= len_s1;
			read_char      <= hit_s1 ? st_rdata : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot_q <= '0;
			rd_slot_q <= '0;
			wr_len_q  <= '0;
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (take) begin
				wr_slot_q <= wr_slot_d;
				rd_slot_q <= rd_slot_d;
				wr_len_q  <= wr_len_d;
			end
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (move_s1) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/text_line_framer_ring_core.sv
// Top level of the text line framer ring: front end, command queue, line engine.
//
// Splits received text bytes into lines held in a ring of LINE_SLOTS line
// slots of LINE_BYTES bytes each. Carriage return is ignored, line feed
// closes a non-empty line, and '>' becomes a one-character line closed at
// once. Once a line holds LINE_BYTES-1 characters further bytes are dropped.
// Closing a line into a full ring drops the oldest line. The reader side
// fetches a character of the oldest line (zero at or past its length),
// releases the oldest line, or clears all lines. Every transaction returns
// exactly one result carrying the state of the oldest slot after it.
// Throughput is one transaction per clock while the result side does not
// stall: the line engine does one store access (write for a received byte,
// read for a character fetch) per transaction. An accepted transaction is
// written into the queue, then passes the engine stage, then the result
// register, where result valid rises. The two-entry queue lets the input
// keep flowing while the result side stalls briefly. The character store
// needs no clearing after reset, so the block takes transactions from the
// first cycle out of reset.
module text_line_framer_ring_core import tlfr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           op,
	input  logic [BYTE_W-1:0]    rx_byte,
	input  logic [OFS_W-1:0]     char_offset,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 line_closed,
	output logic                 dropped_oldest,
	output logic                 oldest_ready,
	output logic [OUT_LEN_W-1:0] oldest_length,
	output logic [BYTE_W-1:0]    read_char
);

	tlfr_item_t front_item;
	tlfr_item_t head_item;
	logic       queue_full;
	logic       head_valid;
	logic       pop;

	// classify the incoming transaction
	tlfr_front u_front (
		.op         (op),
		.rx_byte    (rx_byte),
		.char_offset(char_offset),
		.item       (front_item)
	);

	// input stalls only when the queue is full
	assign in_stall = queue_full;

	tlfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid),
		.push_item (front_item),
		.full      (queue_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_item (head_item)
	);

	// ring pointers, lengths, store and result register
	tlfr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_item     (head_item),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.line_closed   (line_closed),
		.dropped_oldest(dropped_oldest),
		.oldest_ready  (oldest_ready),
		.oldest_length (oldest_length),
		.read_char     (read_char)
	);

endmodule
